FILE: rtl/core/median_window_filter_defines.svh
// Assertion macros shared by the median window filter RTL.
`ifndef MEDIAN_WINDOW_FILTER_DEFINES_SVH
`define MEDIAN_WINDOW_FILTER_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define MWF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define MWF_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mwf_pkg.sv
// Shared constants, types and command structs of the median window filter.
package mwf_pkg;

    localparam int MAX_RADIUS  = 3;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_W       = 11;
    localparam int PIX_W       = 8;
    localparam int RAD_W       = 2;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int WIN_MAX     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNT_W       = $clog2(WIN_MAX + 1);
    localparam int SIDE_W      = $clog2(2 * MAX_RADIUS + 1);
    localparam int BIT_W       = $clog2(PIX_W);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CTR_RD,
        ST_CTR_DATA,
        ST_SCAN,
        ST_TALLY,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic take;
        logic prep;
        logic rd_ctr;
        logic ld_ctr;
        logic scan;
        logic tally;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic win_end;
        logic last_bit;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/median_window_filter.sv
// Top level of the streaming square-window median filter.
// Usage: pixels enter in raster order on the s_ channel (valid/ready); s_operation
// selects a new pixel or a flush item. Results leave on the m_ channel through an
// output register, so the next input item is taken while a result waits.
// A median output trails its input by r*image_width+r pixel items; flush items
// push out the tail of a frame once the frame has been fully written.
// Items are handled one at a time: a new item is not taken until the last is through.
// An item that yields nothing and a border copy need no window scan; an interior median
// is found bit by bit with one line store read per window entry per bit, so the
// single-port line store read sets its cost. Configuration writes (cfg_we, cfg_index,
// cfg_data) are to be made while idle; the block itself does not enforce this. Any
// radius, width or height write restarts the frame, drops pending outputs, keeps the store.
// Reset: radius 1, 640 x 480, positions at zero, no pending output.
// When the receiver stalls, the finished result holds in the output register and
// the block holds off the next result until it is taken.
module median_window_filter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mwf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mwf_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [mwf_pkg::PIX_W-1:0]         s_pixel_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mwf_pkg::PIX_W-1:0]         m_pixel_out,
    output logic                              m_frame_last
);
    import mwf_pkg::*;

    cmd_t    cmd;
    status_t status;

    mwf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mwf_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_operation  (s_operation),
        .s_pixel_in   (s_pixel_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_out  (m_pixel_out),
        .m_frame_last (m_frame_last),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

FILE: rtl/core/mwf_ctrl.sv
// Controller state machine of the median window filter.
module mwf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mwf_pkg::status_t status,
    output mwf_pkg::cmd_t    cmd
);
    import mwf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && status.emit) state_next = ST_PREP;
            end
            ST_PREP: begin
                state_next = status.interior ? ST_SCAN : ST_CTR_RD;
            end
            ST_CTR_RD:   state_next = ST_CTR_DATA;
            ST_CTR_DATA: state_next = ST_DELIVER;
            ST_SCAN: begin
                if (status.win_end) state_next = ST_TALLY;
            end
            ST_TALLY: begin
                state_next = status.last_bit ? ST_DELIVER : ST_SCAN;
            end
            ST_DELIVER: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            ST_PREP:     cmd.prep = 1'b1;
            ST_CTR_RD:   cmd.rd_ctr = 1'b1;
            ST_CTR_DATA: cmd.ld_ctr = 1'b1;
            ST_SCAN:     cmd.scan = 1'b1;
            ST_TALLY:    cmd.tally = 1'b1;
            ST_DELIVER:  cmd.load_out = status.out_free;
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/core/mwf_datapath.sv
// Datapath: configuration, positions, line store, window scan and bitwise median search.
`include "median_window_filter_defines.svh"

module mwf_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mwf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mwf_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                s_operation,
    input  logic [mwf_pkg::PIX_W-1:0]           s_pixel_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [mwf_pkg::PIX_W-1:0]           m_pixel_out,
    output logic                                m_frame_last,
    input  mwf_pkg::cmd_t                       cmd,
    output mwf_pkg::status_t                    status
);
    import mwf_pkg::*;

    logic [PIX_W-1:0]  mem [STORE_DEPTH];

    logic [RAD_W-1:0]  kr_reg;
    logic [DIM_W-1:0]  w_reg;
    logic [DIM_W-1:0]  h_reg;
    logic [RAD_W-1:0]  rr_reg;
    logic [RAD_W-1:0]  rr_next;
    logic [ADDR_W-1:0] lag_reg;
    logic [ADDR_W-1:0] lag_next;

    logic [DIM_W-1:0]  in_row_reg, in_col_reg, out_row_reg, out_col_reg;
    logic [ADDR_W-1:0] pend_reg;
    logic [ADDR_W-1:0] wr_ptr_reg;

    logic [ADDR_W-1:0] center_reg;
    logic [ADDR_W-1:0] top_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] rowstart_reg;
    logic [SIDE_W-1:0] dc_reg, dr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PIX_W-1:0]  ans_reg;
    logic [BIT_W-1:0]  bit_reg;
    logic              rd_vld_reg;
    logic [PIX_W-1:0]  rd_data_reg;
    logic              interior_reg;
    logic              flast_reg;
    logic [PIX_W-1:0]  res_reg;
    logic              m_valid_reg;
    logic [PIX_W-1:0]  m_pixel_reg;
    logic              m_last_reg;

    logic              cfg_hit;
    logic [DIM_W-1:0]  dim_min, rad_lim, cfg_dim;
    logic [RAD_W-1:0]  cfg_rad;
    logic              is_pix;
    logic [ADDR_W-1:0] pend_add, base, wr_inc, wr_new, center_new, top_new;
    logic [ADDR_W:0]   diff, tdiff;
    logic              emit;
    logic              interior;
    logic [DIM_W-1:0]  rr_ext;
    logic [DIM_W-1:0]  in_col_inc, in_row_inc, out_col_inc, out_row_inc;
    logic [SIDE_W-1:0] side;
    logic [ADDR_W:0]   addr_inc, row_inc;
    logic [PIX_W-1:0]  mask, trial, ans_dec;
    logic              hit;
    logic [CNT_W-1:0]  total, need;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Configuration values saturate into their legal ranges.
    always_comb begin
        cfg_rad = (cfg_data[RAD_W-1:0] == '0) ? RAD_W'(1) : cfg_data[RAD_W-1:0];
        cfg_dim = cfg_data[DIM_W-1:0];
        if (cfg_dim < DIM_W'(8)) cfg_dim = DIM_W'(8);
        else if (cfg_dim > DIM_W'(MAX_WIDTH)) cfg_dim = DIM_W'(MAX_WIDTH);
        cfg_hit = cfg_we && (cfg_index == CFG_RADIUS || cfg_index == CFG_WIDTH
                             || cfg_index == CFG_HEIGHT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kr_reg <= RAD_W'(1);
            w_reg  <= DIM_W'(640);
            h_reg  <= DIM_W'(480);
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RADIUS: kr_reg <= cfg_rad;
                CFG_WIDTH:  w_reg  <= cfg_dim;
                CFG_HEIGHT: h_reg  <= cfg_dim;
                default: begin
                end
            endcase
        end
    end

    // Radius in use and output lag are registered, following the configuration registers.
    always_comb begin
        dim_min  = (w_reg < h_reg) ? w_reg : h_reg;
        rad_lim  = (dim_min - DIM_W'(1)) >> 1;
        rr_next  = (DIM_W'(kr_reg) < rad_lim) ? kr_reg : rad_lim[RAD_W-1:0];
        lag_next = ADDR_W'(ADDR_W'(rr_next) * ADDR_W'(w_reg)) + ADDR_W'(rr_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rr_reg  <= RAD_W'(1);
            lag_reg <= ADDR_W'(641);
        end else begin
            rr_reg  <= rr_next;
            lag_reg <= lag_next;
        end
    end

    // Decision for the item on the input port.
    always_comb begin
        is_pix     = (s_operation == OP_PIXEL);
        pend_add   = pend_reg + (is_pix ? ADDR_W'(1) : ADDR_W'(0));
        emit       = is_pix ? (pend_add > lag_reg)
                            : (in_row_reg == '0 && in_col_reg == '0 && pend_reg != '0);
        wr_inc     = (wr_ptr_reg == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wr_ptr_reg + ADDR_W'(1);
        wr_new     = is_pix ? wr_inc : wr_ptr_reg;
        base       = pend_add - ADDR_W'(1);
        diff       = {1'b0, wr_new} - {1'b0, base};
        center_new = diff[ADDR_W] ? ADDR_W'(diff + (ADDR_W+1)'(STORE_DEPTH)) : diff[ADDR_W-1:0];
        rr_ext     = DIM_W'(rr_reg);
        interior   = !(out_row_reg < rr_ext || out_row_reg >= h_reg - rr_ext ||
                       out_col_reg < rr_ext || out_col_reg >= w_reg - rr_ext);
        in_col_inc  = in_col_reg + DIM_W'(1);
        in_row_inc  = in_row_reg + DIM_W'(1);
        out_col_inc = out_col_reg + DIM_W'(1);
        out_row_inc = out_row_reg + DIM_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            pend_reg    <= '0;
            wr_ptr_reg  <= '0;
        end else if (cfg_hit) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            pend_reg    <= '0;
        end else if (cmd.take) begin
            wr_ptr_reg <= wr_new;
            pend_reg   <= emit ? base : pend_add;
            if (is_pix) begin
                if (in_col_inc >= w_reg) begin
                    in_col_reg <= '0;
                    in_row_reg <= (in_row_inc >= h_reg) ? '0 : in_row_inc;
                end else begin
                    in_col_reg <= in_col_inc;
                end
            end
            if (emit) begin
                if (out_col_inc >= w_reg) begin
                    out_col_reg <= '0;
                    out_row_reg <= (out_row_inc >= h_reg) ? '0 : out_row_inc;
                end else begin
                    out_col_reg <= out_col_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && emit) begin
            center_reg   <= center_new;
            interior_reg <= interior;
            flast_reg    <= (out_row_reg == h_reg - DIM_W'(1)) &&
                            (out_col_reg == w_reg - DIM_W'(1));
        end
    end

    // Window scan: addresses walk the rows of the window, wrapping around the store.
    always_comb begin
        tdiff    = {1'b0, center_reg} - {1'b0, lag_reg};
        top_new  = tdiff[ADDR_W] ? ADDR_W'(tdiff + (ADDR_W+1)'(STORE_DEPTH)) : tdiff[ADDR_W-1:0];
        side     = SIDE_W'({rr_reg, 1'b0});
        addr_inc = {1'b0, addr_reg} + (ADDR_W+1)'(1);
        row_inc  = {1'b0, rowstart_reg} + (ADDR_W+1)'(w_reg);
        if (addr_inc >= (ADDR_W+1)'(STORE_DEPTH)) addr_inc = addr_inc - (ADDR_W+1)'(STORE_DEPTH);
        if (row_inc >= (ADDR_W+1)'(STORE_DEPTH)) row_inc = row_inc - (ADDR_W+1)'(STORE_DEPTH);
        // Bits above the one under test are decided; the lower ones are all set in the trial.
        mask     = (PIX_W'(1) << bit_reg) - PIX_W'(1);
        trial    = ans_reg | mask;
        hit      = rd_vld_reg && (rd_data_reg <= trial);
        total    = cnt_reg + CNT_W'(hit);
        need     = CNT_W'(((CNT_W'(side) + CNT_W'(1)) * (CNT_W'(side) + CNT_W'(1))
                           + CNT_W'(1)) >> 1);
        ans_dec  = (total >= need) ? ans_reg : (ans_reg | (PIX_W'(1) << bit_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            top_reg      <= top_new;
            addr_reg     <= top_new;
            rowstart_reg <= top_new;
            dc_reg       <= '0;
            dr_reg       <= '0;
            cnt_reg      <= '0;
            ans_reg      <= '0;
            bit_reg      <= BIT_W'(PIX_W - 1);
        end else if (cmd.scan) begin
            cnt_reg <= total;
            if (dc_reg == side) begin
                dc_reg       <= '0;
                dr_reg       <= dr_reg + SIDE_W'(1);
                rowstart_reg <= row_inc[ADDR_W-1:0];
                addr_reg     <= row_inc[ADDR_W-1:0];
            end else begin
                dc_reg   <= dc_reg + SIDE_W'(1);
                addr_reg <= addr_inc[ADDR_W-1:0];
            end
        end else if (cmd.tally) begin
            cnt_reg      <= '0;
            ans_reg      <= ans_dec;
            bit_reg      <= bit_reg - BIT_W'(1);
            addr_reg     <= top_reg;
            rowstart_reg <= top_reg;
            dc_reg       <= '0;
            dr_reg       <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_ctr) begin
            res_reg <= rd_data_reg;
        end else if (cmd.tally && bit_reg == '0) begin
            res_reg <= ans_dec;
        end
    end

    // Line store.
    assign wr_en   = cmd.take && is_pix;
    assign rd_en   = cmd.scan || cmd.rd_ctr;
    assign rd_addr = cmd.scan ? addr_reg : center_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_new] <= s_pixel_in;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_pixel_reg <= res_reg;
            m_last_reg  <= flast_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_frame_last = m_last_reg;

    always_comb begin
        status.emit     = emit;
        status.interior = interior_reg;
        status.win_end  = (dc_reg == side) && (dr_reg == side);
        status.last_bit = (bit_reg == '0);
        status.out_free = !m_valid_reg || m_ready;
    end

    `MWF_ASSERT_ALWAYS(a_pend_bound, pend_reg <= lag_reg, "pending count exceeds lag")
    `MWF_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(WIN_MAX), "window count overflow")
    `MWF_ASSERT_IMPLY(a_no_rw_clash, wr_en, !rd_en, "store read and write in one cycle")
    `MWF_ASSERT_IMPLY(a_addr_range, cmd.scan, addr_reg < ADDR_W'(STORE_DEPTH),
                      "scan address beyond store")

endmodule
